FILE: src/adaptive_curve_flattener_core_assert.svh
// Assertion macros for the curve flattener.
// Used by the top level; needs a clock and an active-low reset in scope.
`ifndef ADAPTIVE_CURVE_FLATTENER_CORE_ASSERT_SVH
`define ADAPTIVE_CURVE_FLATTENER_CORE_ASSERT_SVH
// same-cycle implication
`define ACF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ACF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/acf_pkg.sv
// Shared types and constants of the curve flattener.
// No dependencies.
`default_nettype none
package acf_pkg;
  localparam int MAX_LEVEL_DEF   = 4;
  localparam int COORD_WIDTH_DEF = 24;
  localparam int FRAC_EXTRA      = 8;
  localparam int TOL_W           = 32;
  localparam int EPS_W           = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 32;
  localparam int MAX_MIDS        = 32;
  localparam int CNT_W           = 6;
  localparam int OP_W            = 33;
  localparam int PROD_W          = 2 * OP_W;
  localparam int ACC_W           = PROD_W + 64;

  localparam logic [TOL_W-1:0] TOL_RESET = 32'd16384;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd0;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TOLERANCE_SQ  = 1'b0;
  localparam cfg_idx_t CFG_COLLINEAR_EPS = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_EVAL,
    S_L0, S_L1, S_LW,
    S_C1A, S_C1B, S_C1W, S_ST2,
    S_C2A, S_C2B, S_C2W, S_ST3,
    S_DEC,
    S_N0, S_N1, S_NW, S_NCHK,
    S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_Q5, S_QW, S_QCHK,
    S_RES, S_POP, S_POPW, S_FIN
  } state_t;

  typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;
  typedef enum logic [1:0] {SH_0, SH_32, SH_64} acc_sh_t;

  typedef struct packed {
    logic seg_start;
    logic push;
    logic is_end;
  } emit_ctl_t;

  typedef struct packed {
    logic push_ready;
    logic held_v;
  } emit_sts_t;
endpackage
`default_nettype wire

FILE: src/acf_mul.sv
// Shared registered signed multiplier of the flattener.
// Uses acf_pkg for operand widths.
`default_nettype none
module acf_mul (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [acf_pkg::OP_W-1:0]    op_a,
  input  wire logic signed [acf_pkg::OP_W-1:0]    op_b,
  output logic signed [acf_pkg::PROD_W-1:0]       prod_r
);
  import acf_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end
endmodule
`default_nettype wire

FILE: src/acf_stack.sv
// Stack memory of pending right halves for depth-first subdivision.
// Standalone; widths handed down from the top level.
`default_nettype none
module acf_stack #(
  parameter int DEPTH = 5,
  parameter int AW    = 3,
  parameter int RW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [RW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [RW-1:0]      rd_data_r
);
  logic [RW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

FILE: src/acf_out.sv
// Result side: duplicate drop, one-point hold for the last flag, output register.
// Uses acf_pkg for the control and status structs.
`default_nettype none
module acf_out #(
  parameter int CW = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire acf_pkg::emit_ctl_t    ctl,
  input  wire logic signed [CW-1:0]  start_x,
  input  wire logic signed [CW-1:0]  start_y,
  input  wire logic signed [CW-1:0]  push_x,
  input  wire logic signed [CW-1:0]  push_y,
  output acf_pkg::emit_sts_t         sts,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [CW-1:0]       out_point_x,
  output logic signed [CW-1:0]       out_point_y,
  output logic                       out_last_point
);
  import acf_pkg::*;

  logic signed [CW-1:0] prev_x_r, prev_y_r, held_x_r, held_y_r;
  logic                 held_v_r, held_last_r, out_v_r, out_last_r;
  logic signed [CW-1:0] out_x_r, out_y_r;
  logic [CNT_W-1:0]     count_r;

  logic eq, drop_mid, out_free, move, push_ready, take, flush;

  always_comb begin
    eq         = (push_x == prev_x_r) && (push_y == prev_y_r);
    drop_mid   = eq || (count_r >= CNT_W'(MAX_MIDS));
    out_free   = !out_v_r || !out_stall;
    move       = held_v_r && (ctl.is_end ? !eq : !drop_mid);
    push_ready = !(held_v_r && held_last_r) && (!move || out_free);
    take       = ctl.push && push_ready;
    flush      = held_v_r && held_last_r && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if ((take && move) || flush) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((take && move) || flush) begin
      out_x_r    <= held_x_r;
      out_y_r    <= held_y_r;
      out_last_r <= flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r    <= 1'b0;
      held_last_r <= 1'b0;
      count_r     <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
    end else if (ctl.seg_start) begin
      held_v_r    <= 1'b0;
      held_last_r <= 1'b0;
      count_r     <= '0;
      prev_x_r    <= start_x;
      prev_y_r    <= start_y;
    end else if (flush) begin
      held_v_r <= 1'b0;
    end else if (take) begin
      if (ctl.is_end && eq) begin
        // end point repeats: mark the held point as last
        held_last_r <= held_v_r;
      end else if (ctl.is_end || !drop_mid) begin
        held_v_r    <= 1'b1;
        held_last_r <= ctl.is_end;
        prev_x_r    <= push_x;
        prev_y_r    <= push_y;
        if (!ctl.is_end) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && (ctl.is_end ? !eq : !drop_mid)) begin
      held_x_r <= push_x;
      held_y_r <= push_y;
    end
  end

  assign sts.push_ready = push_ready;
  assign sts.held_v     = held_v_r;
  assign out_valid      = out_v_r;
  assign out_point_x    = out_x_r;
  assign out_point_y    = out_y_r;
  assign out_last_point = out_last_r;
endmodule
`default_nettype wire

FILE: src/adaptive_curve_flattener_core.sv
// Top level of the curve flattener: sequencer, node datapath, accumulator.
// Uses acf_pkg, acf_mul, acf_stack, acf_out and the assertion macro header.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | command, start, ctrl1, ctrl2, end
//  out     | output    | out_valid/out_stall| point_x, point_y, last_point
//  cfg     | input     | cfg_wr_en          | cfg_index, cfg_data
//
// One segment is evaluated as a forced cubic root node and tested nodes, up to 63
// nodes; the work is set by the single 33x33 multiplier, one product per cycle,
// and its accumulator.
// Reset is synchronous and clears control state; no memory clearing pass is run.
// A stalled result waits in the output register and the one-point hold; a new
// item is taken once the hold is empty and the sequencer is idle.
`default_nettype none
`include "adaptive_curve_flattener_core_assert.svh"
module adaptive_curve_flattener_core #(
  parameter int MAX_LEVEL   = acf_pkg::MAX_LEVEL_DEF,
  parameter int COORD_WIDTH = acf_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_command,
  input  wire logic signed [COORD_WIDTH-1:0]     in_start_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_start_y,
  input  wire logic signed [COORD_WIDTH-1:0]     in_ctrl1_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_ctrl1_y,
  input  wire logic signed [COORD_WIDTH-1:0]     in_ctrl2_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_ctrl2_y,
  input  wire logic signed [COORD_WIDTH-1:0]     in_end_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_end_y,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [COORD_WIDTH-1:0]          out_point_x,
  output logic signed [COORD_WIDTH-1:0]          out_point_y,
  output logic                                   out_last_point,
  input  wire logic                              cfg_wr_en,
  input  wire acf_pkg::cfg_idx_t                 cfg_index,
  input  wire logic [acf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import acf_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int CWI   = CW + FRAC_EXTRA;
  localparam int DEPTH = MAX_LEVEL + 1;
  localparam int LW    = $clog2(MAX_LEVEL + 2);
  localparam int SPW   = $clog2(DEPTH + 1);
  localparam int SAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = 8 * CWI + LW;

  function automatic logic signed [CWI-1:0] midp(input logic signed [CWI-1:0] a,
                                                  input logic signed [CWI-1:0] b);
    logic signed [CWI:0] s;
    s = {a[CWI-1], a} + {b[CWI-1], b};
    return s[CWI:1];
  endfunction

  function automatic logic signed [31:0] mdiff(input logic signed [CWI-1:0] a,
                                               input logic signed [CWI-1:0] b);
    logic signed [CWI:0] d;
    logic signed [CW:0]  q;
    logic signed [33:0]  w;
    d = {a[CWI-1], a} - {b[CWI-1], b};
    q = d[CWI:FRAC_EXTRA];
    w = {{(33 - CW){q[CW]}}, q};
    if (w > 34'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (w < -34'sd2147483647) begin
      return 32'sh80000001;
    end else begin
      return w[31:0];
    end
  endfunction

  function automatic logic signed [CW-1:0] rnd(input logic signed [CWI-1:0] v);
    logic signed [CWI:0] s;
    s = {v[CWI-1], v} + (CWI+1)'(128);
    return s[CWI-1:FRAC_EXTRA];
  endfunction

  // state and registers
  state_t                state_r, state_nxt;
  logic [TOL_W-1:0]      tol_r;
  logic [EPS_W-1:0]      eps_r;
  logic signed [CWI-1:0] nx_r [4];
  logic signed [CWI-1:0] ny_r [4];
  logic signed [CW-1:0]  end_x_r, end_y_r;
  logic                  quad_r, flat_r;
  logic [LW-1:0]         level_r;
  logic [SPW-1:0]        sp_r;
  logic [63:0]           len2_r, d2_r, d3_r, s_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  acc_op_t               acc_op_r, acc_op;
  acc_sh_t               acc_sh_r, acc_sh;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // midpoints of the current node
  logic signed [CWI-1:0] x12, x23, x34, x123, x234, mxc, mx, endx;
  logic signed [CWI-1:0] y12, y23, y34, y123, y234, myc, my, endy;
  logic signed [31:0]    dx, dy, p1x, p1y, p2x, p2y, ex, ey;

  always_comb begin
    x12  = midp(nx_r[0], nx_r[1]);  y12  = midp(ny_r[0], ny_r[1]);
    x23  = midp(nx_r[1], nx_r[2]);  y23  = midp(ny_r[1], ny_r[2]);
    x34  = midp(nx_r[2], nx_r[3]);  y34  = midp(ny_r[2], ny_r[3]);
    x123 = midp(x12, x23);          y123 = midp(y12, y23);
    x234 = midp(x23, x34);          y234 = midp(y23, y34);
    mxc  = midp(x123, x234);        myc  = midp(y123, y234);
    mx   = quad_r ? x123 : mxc;
    my   = quad_r ? y123 : myc;
    endx = quad_r ? nx_r[2] : nx_r[3];
    endy = quad_r ? ny_r[2] : ny_r[3];
    dx   = mdiff(endx, nx_r[0]);
    dy   = mdiff(endy, ny_r[0]);
    p1x  = mdiff(nx_r[1], endx);
    p1y  = mdiff(ny_r[1], endy);
    p2x  = mdiff(nx_r[2], endx);
    p2y  = mdiff(ny_r[2], endy);
    ex   = mdiff(mx, midp(nx_r[0], endx));
    ey   = mdiff(my, midp(ny_r[0], endy));
  end

  // flatness branch selection
  logic b2, b3, can_split;
  always_comb begin
    b2        = d2_r > {48'b0, eps_r};
    b3        = !quad_r && (d3_r > {48'b0, eps_r});
    can_split = (level_r <= LW'(MAX_LEVEL)) && (sp_r < SPW'(DEPTH));
  end

  // shared multiplier
  logic signed [OP_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0] prod_r;

  acf_mul u_mul (
    .clk    (clk),
    .en     (acc_op != ACC_NONE),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // stack of right halves
  logic          stk_wr, stk_rd;
  logic [RW-1:0] stk_wdata, stk_rdata;
  logic [SPW-1:0] sp_dec;
  assign sp_dec = sp_r - SPW'(1);

  acf_stack #(.DEPTH(DEPTH), .AW(SAW), .RW(RW)) u_stack (
    .clk       (clk),
    .wr_en     (stk_wr),
    .wr_addr   (sp_r[SAW-1:0]),
    .wr_data   (stk_wdata),
    .rd_en     (stk_rd),
    .rd_addr   (sp_dec[SAW-1:0]),
    .rd_data_r (stk_rdata)
  );

  always_comb begin
    stk_wdata = {LW'(level_r + LW'(1)),
                 quad_r ? x123 : mxc, quad_r ? x23 : x234, quad_r ? nx_r[2] : x34,
                 quad_r ? CWI'(0) : nx_r[3],
                 quad_r ? y123 : myc, quad_r ? y23 : y234, quad_r ? ny_r[2] : y34,
                 quad_r ? CWI'(0) : ny_r[3]};
  end

  // result side
  emit_ctl_t            ectl;
  emit_sts_t            ests;
  logic signed [CW-1:0] push_x, push_y;

  acf_out #(.CW(CW)) u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ectl),
    .start_x        (in_start_x),
    .start_y        (in_start_y),
    .push_x         (push_x),
    .push_y         (push_y),
    .sts            (ests),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point)
  );

  assign in_stall = (state_r != S_IDLE) || ests.held_v;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_EVAL;
      S_EVAL:  state_nxt = (!quad_r && level_r == '0) ? S_RES : S_L0;
      S_L0:    state_nxt = S_L1;
      S_L1:    state_nxt = S_LW;
      S_LW:    state_nxt = S_C1A;
      S_C1A:   state_nxt = S_C1B;
      S_C1B:   state_nxt = S_C1W;
      S_C1W:   state_nxt = S_ST2;
      S_ST2:   state_nxt = quad_r ? S_DEC : S_C2A;
      S_C2A:   state_nxt = S_C2B;
      S_C2B:   state_nxt = S_C2W;
      S_C2W:   state_nxt = S_ST3;
      S_ST3:   state_nxt = S_DEC;
      S_DEC:   state_nxt = (b2 || b3) ? S_Q0 : S_N0;
      S_N0:    state_nxt = S_N1;
      S_N1:    state_nxt = S_NW;
      S_NW:    state_nxt = S_NCHK;
      S_NCHK:  state_nxt = S_RES;
      S_Q0:    state_nxt = S_Q1;
      S_Q1:    state_nxt = S_Q2;
      S_Q2:    state_nxt = S_Q3;
      S_Q3:    state_nxt = S_Q4;
      S_Q4:    state_nxt = S_Q5;
      S_Q5:    state_nxt = S_QW;
      S_QW:    state_nxt = S_QCHK;
      S_QCHK:  state_nxt = S_RES;
      S_RES: begin
        if (flat_r) begin
          if (ests.push_ready) state_nxt = S_POP;
        end else if (can_split) begin
          state_nxt = S_EVAL;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP:   state_nxt = (sp_r == '0) ? S_FIN : S_POPW;
      S_POPW:  state_nxt = S_EVAL;
      S_FIN:   if (ests.push_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    acc_op = ACC_NONE;
    acc_sh = SH_0;
    case (state_r)
      S_L0:  begin op_a = {dx[31], dx};   op_b = {dx[31], dx};   acc_op = ACC_LOAD; end
      S_L1:  begin op_a = {dy[31], dy};   op_b = {dy[31], dy};   acc_op = ACC_ADD;  end
      S_C1A: begin op_a = {p1x[31], p1x}; op_b = {dy[31], dy};   acc_op = ACC_LOAD; end
      S_C1B: begin op_a = {p1y[31], p1y}; op_b = {dx[31], dx};   acc_op = ACC_SUB;  end
      S_C2A: begin op_a = {p2x[31], p2x}; op_b = {dy[31], dy};   acc_op = ACC_LOAD; end
      S_C2B: begin op_a = {p2y[31], p2y}; op_b = {dx[31], dx};   acc_op = ACC_SUB;  end
      S_N0:  begin op_a = {ex[31], ex};   op_b = {ex[31], ex};   acc_op = ACC_LOAD; end
      S_N1:  begin op_a = {ey[31], ey};   op_b = {ey[31], ey};   acc_op = ACC_ADD;  end
      S_Q0:  begin
        op_a = {1'b0, s_r[31:0]};  op_b = {1'b0, s_r[31:0]};  acc_op = ACC_LOAD;
      end
      S_Q1, S_Q2: begin
        op_a = {1'b0, s_r[31:0]};  op_b = {1'b0, s_r[63:32]}; acc_op = ACC_ADD;
        acc_sh = SH_32;
      end
      S_Q3:  begin
        op_a = {1'b0, s_r[63:32]}; op_b = {1'b0, s_r[63:32]}; acc_op = ACC_ADD;
        acc_sh = SH_64;
      end
      S_Q4:  begin
        op_a = {1'b0, tol_r};      op_b = {1'b0, len2_r[31:0]};  acc_op = ACC_SUB;
      end
      S_Q5:  begin
        op_a = {1'b0, tol_r};      op_b = {1'b0, len2_r[63:32]}; acc_op = ACC_SUB;
        acc_sh = SH_32;
      end
      default: begin
        acc_op = ACC_NONE;
      end
    endcase

    stk_wr = (state_r == S_RES) && !flat_r && can_split;
    stk_rd = (state_r == S_POP) && (sp_r != '0);

    ectl.seg_start = in_acc;
    ectl.push      = ((state_r == S_RES) && flat_r) || (state_r == S_FIN);
    ectl.is_end    = (state_r == S_FIN);
    push_x         = (state_r == S_FIN) ? end_x_r : rnd(mx);
    push_y         = (state_r == S_FIN) ? end_y_r : rnd(my);
  end

  // accumulator, fed in the cycle after the product is issued
  logic signed [ACC_W-1:0] term, acc_mag;
  always_comb begin
    term = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    case (acc_sh_r)
      SH_32:   term = term <<< 32;
      SH_64:   term = term <<< 64;
      default: term = term;
    endcase
    case (acc_op_r)
      ACC_LOAD: acc_nxt = term;
      ACC_ADD:  acc_nxt = acc_r + term;
      ACC_SUB:  acc_nxt = acc_r - term;
      default:  acc_nxt = acc_r;
    endcase
    acc_mag = acc_r[ACC_W-1] ? -acc_r : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      acc_op_r <= ACC_NONE;
      acc_sh_r <= SH_0;
      tol_r    <= TOL_RESET;
      eps_r    <= EPS_RESET;
      level_r  <= '0;
      sp_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      acc_op_r <= acc_op;
      acc_sh_r <= acc_sh;
      if (cfg_wr_en && cfg_index == CFG_TOLERANCE_SQ) begin
        tol_r <= cfg_data[TOL_W-1:0];
      end
      if (cfg_wr_en && cfg_index == CFG_COLLINEAR_EPS) begin
        eps_r <= cfg_data[EPS_W-1:0];
      end
      if (in_acc) begin
        level_r <= '0;
        sp_r    <= '0;
      end else if (stk_wr) begin
        level_r <= level_r + LW'(1);
        sp_r    <= sp_r + SPW'(1);
      end else if (stk_rd) begin
        sp_r <= sp_dec;
      end else if (state_r == S_POPW) begin
        level_r <= stk_rdata[RW-1 -: LW];
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          quad_r  <= in_command;
          end_x_r <= in_end_x;
          end_y_r <= in_end_y;
          nx_r[0] <= {in_start_x, 8'b0};
          ny_r[0] <= {in_start_y, 8'b0};
          nx_r[1] <= {in_ctrl1_x, 8'b0};
          ny_r[1] <= {in_ctrl1_y, 8'b0};
          nx_r[2] <= in_command ? {in_end_x, 8'b0} : {in_ctrl2_x, 8'b0};
          ny_r[2] <= in_command ? {in_end_y, 8'b0} : {in_ctrl2_y, 8'b0};
          nx_r[3] <= in_command ? CWI'(0) : {in_end_x, 8'b0};
          ny_r[3] <= in_command ? CWI'(0) : {in_end_y, 8'b0};
        end
      end
      S_EVAL:  flat_r <= 1'b0;
      S_C1A:   len2_r <= acc_r[63:0];
      S_ST2:   d2_r   <= acc_mag[63:0];
      S_ST3:   d3_r   <= acc_mag[63:0];
      S_DEC: begin
        if (b2 && b3) begin
          s_r <= d2_r + d3_r;
        end else if (b2) begin
          s_r <= d2_r;
        end else begin
          s_r <= d3_r;
        end
      end
      S_NCHK:  flat_r <= acc_r[63:0] <= {32'b0, tol_r};
      S_QCHK:  flat_r <= acc_r[ACC_W-1] || (acc_r == '0);
      S_RES: begin
        // descend into the left half
        if (!flat_r && can_split) begin
          nx_r[1] <= x12;
          ny_r[1] <= y12;
          nx_r[2] <= x123;
          ny_r[2] <= y123;
          nx_r[3] <= quad_r ? CWI'(0) : mxc;
          ny_r[3] <= quad_r ? CWI'(0) : myc;
        end
      end
      S_POPW: begin
        nx_r[0] <= stk_rdata[8*CWI-1 -: CWI];
        nx_r[1] <= stk_rdata[7*CWI-1 -: CWI];
        nx_r[2] <= stk_rdata[6*CWI-1 -: CWI];
        nx_r[3] <= stk_rdata[5*CWI-1 -: CWI];
        ny_r[0] <= stk_rdata[4*CWI-1 -: CWI];
        ny_r[1] <= stk_rdata[3*CWI-1 -: CWI];
        ny_r[2] <= stk_rdata[2*CWI-1 -: CWI];
        ny_r[3] <= stk_rdata[CWI-1 -: CWI];
      end
      default: begin
        flat_r <= flat_r;
      end
    endcase
  end

  `ACF_ASSERT_NXT(a_accept_starts, clk, rst_n, in_valid && !in_stall, state_r == S_EVAL)
  `ACF_ASSERT_IMP(a_eval_level, clk, rst_n, state_r == S_EVAL, (level_r <= LW'(MAX_LEVEL + 1)) && (SPW'(level_r) >= sp_r))
  `ACF_ASSERT_IMP(a_pop_moves_sp, clk, rst_n, state_r == S_POPW, $past(sp_r) == sp_r + SPW'(1))
endmodule
`default_nettype wire
